>>> rtl/core/quadrature_detent_button_decoder_core_assert.svh
// Assertion macros for the quadrature detent decoder.
// Each macro expects clk and rst_n in scope.
`ifndef QUADRATURE_DETENT_BUTTON_DECODER_CORE_ASSERT_SVH
`define QUADRATURE_DETENT_BUTTON_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define QDBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define QDBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qdbd_pkg.sv
package qdbd_pkg;

    // Event codes on the result channel
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_RIGHT = 2'd1;
    localparam logic [1:0] EV_LEFT  = 2'd2;
    localparam logic [1:0] EV_PRESS = 2'd3;

    // Configuration register indexes
    localparam logic CFG_STEPS_PER_DETENT = 1'b0;
    localparam logic CFG_DEBOUNCE_MS      = 1'b1;

    // Reset values of the configuration registers
    localparam logic [6:0]  STEPS_RESET    = 7'd4;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    // One encoder/switch sample
    typedef struct packed {
        logic        phase_a;
        logic        phase_b;
        logic        switch_level;
        logic [31:0] time_ms;
    } sample_t;

    // Engine status seen by the top level checks
    typedef struct packed {
        logic primed;
        logic sum_zero;
    } status_t;

    // Quadrature transition table: index is {prev_a, prev_b, cur_a, cur_b}
    function automatic logic signed [1:0] step_of(input logic [3:0] idx);
        logic signed [1:0] step;
        unique case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default:                  step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

>>> rtl/core/qdbd_if.sv
// Sample channel: encoder levels, switch level and millisecond time
interface qdbd_sample_if;
    logic        valid;
    logic        ready;
    logic        phase_a;
    logic        phase_b;
    logic        switch_level;
    logic [31:0] time_ms;

    modport source (output valid, output phase_a, output phase_b,
                    output switch_level, output time_ms, input ready);
    modport sink   (input valid, input phase_a, input phase_b,
                    input switch_level, input time_ms, output ready);
endinterface

// Event channel: one event code per sample
interface qdbd_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

>>> rtl/core/quadrature_detent_button_decoder_core.sv
// The sample passes through the input register, then the result register; its event is valid
// once it reaches the result register, and waits there while event_ch.ready is low.
// Throughput: one sample per cycle while event_ch.ready keeps the result register draining.
// Every sample yields exactly one event item (code 0 when nothing happened).
// Reset (rst_n low, async): steps_per_detent 4, debounce_ms 50, encoder state 3,
// switch released, detent count 0, first sample after reset only loads A/B.
`include "quadrature_detent_button_decoder_core_assert.svh"

module quadrature_detent_button_decoder_core
(
    input  logic          clk,
    input  logic          rst_n,
    qdbd_sample_if.sink   sample_ch,
    qdbd_event_if.source  event_ch,
    input  logic          wr_en,
    input  logic          wr_index,
    input  logic [15:0]   wr_data
);

    logic [6:0]          steps_reg;
    logic [15:0]         debounce_reg;

    logic                s1_valid_reg;
    qdbd_pkg::sample_t   s1_sample_reg;
    logic                out_valid_reg;
    logic [1:0]          out_code_reg;

    logic                advance;
    logic [1:0]          engine_code;
    qdbd_pkg::status_t   engine_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg    <= qdbd_pkg::STEPS_RESET;
            debounce_reg <= qdbd_pkg::DEBOUNCE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                qdbd_pkg::CFG_STEPS_PER_DETENT: steps_reg    <= wr_data[6:0];
                qdbd_pkg::CFG_DEBOUNCE_MS:      debounce_reg <= wr_data;
                default:                        ;
            endcase
        end
    end

    // Stage 1 moves into the result register when it is free or draining
    assign advance         = s1_valid_reg && (!out_valid_reg || event_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            s1_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            s1_sample_reg.phase_a      <= sample_ch.phase_a;
            s1_sample_reg.phase_b      <= sample_ch.phase_b;
            s1_sample_reg.switch_level <= sample_ch.switch_level;
            s1_sample_reg.time_ms      <= sample_ch.time_ms;
        end
    end

    qdbd_engine u_engine
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .sample           (s1_sample_reg),
        .steps_per_detent (steps_reg),
        .debounce_ms      (debounce_reg),
        .event_code       (engine_code),
        .status           (engine_status)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= engine_code;
        end
    end

    assign event_ch.valid      = out_valid_reg;
    assign event_ch.event_code = out_code_reg;

    // Checks
    `QDBD_ASSERT_NEXT(a_first_sample_quiet, advance && !engine_status.primed,
        out_valid_reg && (out_code_reg == qdbd_pkg::EV_NONE) && engine_status.primed,
        "first sample after reset must give no event")
    `QDBD_ASSERT_NEXT(a_stalled_sample_kept, s1_valid_reg && !advance, s1_valid_reg,
        "stalled sample dropped from input register")
    `QDBD_ASSERT_NEXT(a_rotation_clears_sum,
        advance && ((engine_code == qdbd_pkg::EV_RIGHT) || (engine_code == qdbd_pkg::EV_LEFT)),
        engine_status.sum_zero,
        "detent count not cleared after rotation event")

endmodule

>>> rtl/core/qdbd_engine.sv
// Decoder state and per-sample logic: quadrature step, detent count,
// switch debounce. State advances on fire; event_code is combinational.
module qdbd_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  qdbd_pkg::sample_t  sample,
    input  logic [6:0]         steps_per_detent,
    input  logic [15:0]        debounce_ms,
    output logic [1:0]         event_code,
    output qdbd_pkg::status_t  status
);

    logic [1:0]        prev_quad_reg, prev_quad_next;
    logic              primed_reg, primed_next;
    logic signed [7:0] step_sum_reg, step_sum_next;
    logic              raw_switch_reg, raw_switch_next;
    logic              stable_switch_reg, stable_switch_next;
    logic [31:0]       change_time_reg, change_time_next;

    logic [1:0]        cur_quad;
    logic signed [1:0] step;
    logic signed [7:0] sum_step;
    logic signed [8:0] sum_wide;
    logic signed [8:0] limit_pos;
    logic signed [8:0] limit_neg;
    logic              hit_right;
    logic              hit_left;
    logic              sw_changed;
    logic [31:0]       elapsed;
    logic              settled;

    // Quadrature step and detent compare
    assign cur_quad  = {sample.phase_a, sample.phase_b};
    assign step      = qdbd_pkg::step_of({prev_quad_reg, cur_quad});
    assign sum_step  = step_sum_reg + {{6{step[1]}}, step};
    assign sum_wide  = {sum_step[7], sum_step};
    assign limit_pos = $signed({2'b00, steps_per_detent});
    assign limit_neg = -limit_pos;
    assign hit_right = (step != 2'sd0) && (sum_wide >= limit_pos);
    assign hit_left  = (step != 2'sd0) && (sum_wide <= limit_neg);

    // Debounce: time since the last raw level change, wrapping
    assign sw_changed = (sample.switch_level != raw_switch_reg);
    assign elapsed    = sw_changed ? 32'd0 : (sample.time_ms - change_time_reg);
    assign settled    = (elapsed >= {16'd0, debounce_ms});

    // Next state and event
    always_comb
    begin
        prev_quad_next     = cur_quad;
        primed_next        = 1'b1;
        step_sum_next      = step_sum_reg;
        raw_switch_next    = raw_switch_reg;
        stable_switch_next = stable_switch_reg;
        change_time_next   = change_time_reg;
        event_code         = qdbd_pkg::EV_NONE;

        if (primed_reg)
        begin
            if (hit_right)
            begin
                step_sum_next = 8'sd0;
                event_code    = qdbd_pkg::EV_RIGHT;
            end
            else if (hit_left)
            begin
                step_sum_next = 8'sd0;
                event_code    = qdbd_pkg::EV_LEFT;
            end
            else
            begin
                step_sum_next = sum_step;
                if (sw_changed)
                begin
                    change_time_next = sample.time_ms;
                    raw_switch_next  = sample.switch_level;
                end
                if (settled && (sample.switch_level != stable_switch_reg))
                begin
                    stable_switch_next = sample.switch_level;
                    if (!sample.switch_level)
                    begin
                        event_code = qdbd_pkg::EV_PRESS;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_quad_reg     <= 2'b11;
            primed_reg        <= 1'b0;
            step_sum_reg      <= 8'sd0;
            raw_switch_reg    <= 1'b1;
            stable_switch_reg <= 1'b1;
            change_time_reg   <= 32'd0;
        end
        else if (fire)
        begin
            prev_quad_reg     <= prev_quad_next;
            primed_reg        <= primed_next;
            step_sum_reg      <= step_sum_next;
            raw_switch_reg    <= raw_switch_next;
            stable_switch_reg <= stable_switch_next;
            change_time_reg   <= change_time_next;
        end
    end

    assign status.primed   = primed_reg;
    assign status.sum_zero = (step_sum_reg == 8'sd0);

endmodule
